@@ hdl/gbc_pkg.sv @@
// Shared types, constants and helpers for the GSO batch coalescer.
`timescale 1ns / 1ps

package gbc_pkg;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_PLACED       = 2'd0,
    KIND_SLOT_CLOSED  = 2'd1,
    KIND_BATCH_CLOSED = 2'd2
  } kind_e;

  // Config register indexes
  localparam logic [0:0] REG_MAX_SEGS  = 1'b0;
  localparam logic [0:0] REG_MAX_SLOTS = 1'b1;

  // Config reset values
  localparam logic [7:0] MaxSegsReset  = 8'd64;
  localparam logic [6:0] MaxSlotsReset = 7'd64;

  // Hard cap on packets per slot, and saturation point of the batch total
  localparam logic [7:0]  SegCap   = 8'd128;
  localparam logic [13:0] TotalMax = 14'h3FFF;

  // Most results one input beat can cause
  localparam int unsigned MaxResults = 4;

  // One result beat
  typedef struct packed {
    kind_e        kind;
    logic [5:0]   slot_index;
    logic         appended;
    logic [15:0]  segment_size;
    logic [7:0]   segment_count;
    logic [63:0]  slot_peer;
    logic [63:0]  slot_conn;
    logic [6:0]   slots_in_batch;
    logic [13:0]  total_segments;
    logic         needs_offload;
    logic         queue_dry;
    logic         last;
  } result_t;

  // All results caused by one input beat, in delivery order
  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [2:0]               count;
  } bundle_t;

  // Saturating add of a slot's count into the batch total
  function automatic logic [13:0] sat_add(input logic [13:0] a, input logic [7:0] b);
    logic [14:0] sum;
    sum = {1'b0, a} + {7'd0, b};
    if (sum > {1'b0, TotalMax}) begin
      sat_add = TotalMax;
    end else begin
      sat_add = sum[13:0];
    end
  endfunction

endpackage

@@ hdl/gbc_merge.sv @@
// Merge decision, slot/batch state and config registers; builds the result bundle.
`timescale 1ns / 1ps

module gbc_merge
  import gbc_pkg::*;
#(
  parameter int MAX_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        fire_i,
  input  logic        action_i,
  input  logic [15:0] packet_size_i,
  input  logic [63:0] peer_key_i,
  input  logic [63:0] conn_key_i,
  output bundle_t     bundle_o
);

  // Slot limit ceiling: the 7-bit register can never exceed 127
  localparam int LimCap = (MAX_SLOTS < 127) ? MAX_SLOTS : 127;
  localparam logic [6:0] LimCapV = LimCap[6:0];

  // Config registers
  logic [7:0]  cfg_segs_q;
  logic [6:0]  cfg_slots_q;

  // Control state
  logic        slot_open_q, slot_open_d;
  logic [6:0]  slot_count_q, slot_count_d;
  logic [13:0] batch_seg_q, batch_seg_d;
  logic        batch_off_q, batch_off_d;
  logic [6:0]  batch_lim_q, batch_lim_d;

  // Open slot payload
  logic [15:0] prev_size_q, prev_size_d;
  logic [15:0] open_seg_q, open_seg_d;
  logic [7:0]  open_cnt_q, open_cnt_d;
  logic [63:0] open_peer_q, open_peer_d;
  logic [63:0] open_conn_q, open_conn_d;

  // Decision terms
  logic [7:0]  seg_lim;
  logic [6:0]  cfg_lim;
  logic [6:0]  lim_eff;
  logic [6:0]  cnt_new;
  logic        can_append;
  logic        close_old;
  logic        hit_limit;
  logic [13:0] tot1, tot2;
  logic        off1;
  result_t     r_old, r_place, r_new, r_batch;
  bundle_t     bnd;

  // Merge decision and next state
  always_comb begin
    seg_lim = (cfg_segs_q > SegCap) ? SegCap : cfg_segs_q;
    cfg_lim = cfg_slots_q;
    if (cfg_lim < 7'd1) begin
      cfg_lim = 7'd1;
    end
    if (cfg_lim > LimCapV) begin
      cfg_lim = LimCapV;
    end
    lim_eff = (slot_count_q == 7'd0) ? cfg_lim : batch_lim_q;
    cnt_new = slot_count_q + 7'd1;

    can_append = !action_i && slot_open_q && (packet_size_i <= prev_size_q) &&
                 ((open_seg_q == 16'd0) || (open_seg_q == prev_size_q)) &&
                 (peer_key_i == open_peer_q) && (conn_key_i == open_conn_q) &&
                 (open_cnt_q < seg_lim);
    close_old  = slot_open_q && (action_i || !can_append);
    hit_limit  = !action_i && !can_append && (cnt_new >= lim_eff);

    tot1 = close_old ? sat_add(batch_seg_q, open_cnt_q) : batch_seg_q;
    off1 = batch_off_q | (close_old && (open_seg_q != 16'd0));
    tot2 = hit_limit ? sat_add(tot1, 8'd1) : tot1;

    // Old slot closing
    r_old               = '0;
    r_old.kind          = KIND_SLOT_CLOSED;
    r_old.slot_index    = slot_count_q[5:0] - 6'd1;
    r_old.segment_size  = open_seg_q;
    r_old.segment_count = open_cnt_q;
    r_old.slot_peer     = open_peer_q;
    r_old.slot_conn     = open_conn_q;

    // Packet placed
    r_place            = '0;
    r_place.kind       = KIND_PLACED;
    r_place.appended   = can_append;
    r_place.slot_index = can_append ? (slot_count_q[5:0] - 6'd1) : slot_count_q[5:0];

    // New single-packet slot closing at the slot limit
    r_new               = '0;
    r_new.kind          = KIND_SLOT_CLOSED;
    r_new.slot_index    = slot_count_q[5:0];
    r_new.segment_count = 8'd1;
    r_new.slot_peer     = peer_key_i;
    r_new.slot_conn     = conn_key_i;

    // Batch closing
    r_batch                = '0;
    r_batch.kind           = KIND_BATCH_CLOSED;
    r_batch.slots_in_batch = action_i ? slot_count_q : cnt_new;
    r_batch.total_segments = action_i ? tot1 : tot2;
    r_batch.needs_offload  = off1;
    r_batch.queue_dry      = action_i;

    // Pack results in delivery order
    bnd = '0;
    if (close_old) begin
      bnd.res[bnd.count[1:0]] = r_old;
      bnd.count = bnd.count + 3'd1;
    end
    if (!action_i) begin
      bnd.res[bnd.count[1:0]] = r_place;
      bnd.count = bnd.count + 3'd1;
    end
    if (hit_limit) begin
      bnd.res[bnd.count[1:0]] = r_new;
      bnd.count = bnd.count + 3'd1;
    end
    if (action_i || hit_limit) begin
      bnd.res[bnd.count[1:0]] = r_batch;
      bnd.count = bnd.count + 3'd1;
    end
    bnd.res[bnd.count[1:0] - 2'd1].last = 1'b1;

    // Next state
    slot_open_d  = slot_open_q;
    slot_count_d = slot_count_q;
    batch_seg_d  = batch_seg_q;
    batch_off_d  = batch_off_q;
    batch_lim_d  = batch_lim_q;
    prev_size_d  = prev_size_q;
    open_seg_d   = open_seg_q;
    open_cnt_d   = open_cnt_q;
    open_peer_d  = open_peer_q;
    open_conn_d  = open_conn_q;
    priority if (action_i || hit_limit) begin
      slot_open_d  = 1'b0;
      slot_count_d = 7'd0;
      batch_seg_d  = 14'd0;
      batch_off_d  = 1'b0;
      batch_lim_d  = 7'd0;
    end else if (can_append) begin
      open_seg_d  = prev_size_q;
      prev_size_d = packet_size_i;
      open_cnt_d  = open_cnt_q + 8'd1;
    end else begin
      slot_open_d  = 1'b1;
      slot_count_d = cnt_new;
      batch_seg_d  = tot1;
      batch_off_d  = off1;
      batch_lim_d  = lim_eff;
      prev_size_d  = packet_size_i;
      open_seg_d   = 16'd0;
      open_cnt_d   = 8'd1;
      open_peer_d  = peer_key_i;
      open_conn_d  = conn_key_i;
    end
  end

  assign bundle_o = bnd;

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_segs_q  <= MaxSegsReset;
      cfg_slots_q <= MaxSlotsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MAX_SEGS:  cfg_segs_q  <= cfg_data_i;
        REG_MAX_SLOTS: cfg_slots_q <= cfg_data_i[6:0];
        default:       cfg_segs_q  <= cfg_segs_q;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_open_q  <= 1'b0;
      slot_count_q <= 7'd0;
      batch_seg_q  <= 14'd0;
      batch_off_q  <= 1'b0;
      batch_lim_q  <= 7'd0;
    end else if (fire_i) begin
      slot_open_q  <= slot_open_d;
      slot_count_q <= slot_count_d;
      batch_seg_q  <= batch_seg_d;
      batch_off_q  <= batch_off_d;
      batch_lim_q  <= batch_lim_d;
    end
  end

  // Open slot payload; only read while a slot is open
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      prev_size_q <= prev_size_d;
      open_seg_q  <= open_seg_d;
      open_cnt_q  <= open_cnt_d;
      open_peer_q <= open_peer_d;
      open_conn_q <= open_conn_d;
    end
  end

endmodule

@@ hdl/gbc_result_queue.sv @@
// Result bank: holds one input's results; hands out one beat per cycle unless stalled.
`timescale 1ns / 1ps

module gbc_result_queue
  import gbc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  bundle_t bundle_i,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output result_t result_o,
  output logic    busy_o,
  output logic    final_take_o
);

  result_t [MaxResults-1:0] res_q;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;
  logic       take;

  // Handout control
  assign out_valid_o  = (cnt_q != 3'd0);
  assign take         = out_valid_o && !out_stall_i;
  assign final_take_o = take && ({1'b0, idx_q} == (cnt_q - 3'd1));
  assign busy_o       = out_valid_o;
  assign result_o     = res_q[idx_q];

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    priority if (load_i) begin
      cnt_d = bundle_i.count;
      idx_d = 2'd0;
    end else if (final_take_o) begin
      cnt_d = 3'd0;
      idx_d = 2'd0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      idx_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= bundle_i.res;
    end
  end

endmodule

@@ hdl/gso_batch_coalescer_core.sv @@
// Top level of the GSO batch coalescer: packet descriptors in, slot and batch events out.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------------------
//  in       | in_valid_i / in_stall_o  | action, packet_size, peer_key, conn_key
//  out      | out_valid_o / out_stall_i| kind, slot_index, appended, segment_size, ...
//  config   | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// Each input beat is decided in the cycle it is accepted and its 1 to 4 results land in
// the result registers; they leave one beat per cycle while the output is not stalled,
// and a plain packet has one result.
// The next input beat is taken in the cycle the previous one's last result is taken.
// Reset clears the slot and batch state and loads config defaults; no clearing pass.
// A stall on the output holds the current result and, on its last result, the input.
`timescale 1ns / 1ps

module gso_batch_coalescer_core
  import gbc_pkg::*;
#(
  parameter int MAX_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [15:0] packet_size_i,
  input  logic [63:0] peer_key_i,
  input  logic [63:0] conn_key_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [5:0]  slot_index_o,
  output logic        appended_o,
  output logic [15:0] segment_size_o,
  output logic [7:0]  segment_count_o,
  output logic [63:0] slot_peer_o,
  output logic [63:0] slot_conn_o,
  output logic [6:0]  slots_in_batch_o,
  output logic [13:0] total_segments_o,
  output logic        needs_offload_o,
  output logic        queue_dry_o,
  output logic        last_o
);

  logic    fire;
  logic    busy;
  logic    final_take;
  bundle_t bundle;
  result_t result;

  // Input is free when no results wait or the last one leaves this cycle
  assign in_stall_o = busy && !final_take;
  assign fire       = in_valid_i && !in_stall_o;

  gbc_merge #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fire_i       (fire),
    .action_i     (action_i),
    .packet_size_i(packet_size_i),
    .peer_key_i   (peer_key_i),
    .conn_key_i   (conn_key_i),
    .bundle_o     (bundle)
  );

  gbc_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .bundle_i    (bundle),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (result),
    .busy_o      (busy),
    .final_take_o(final_take)
  );

  // Result fields
  assign kind_o           = result.kind;
  assign slot_index_o     = result.slot_index;
  assign appended_o       = result.appended;
  assign segment_size_o   = result.segment_size;
  assign segment_count_o  = result.segment_count;
  assign slot_peer_o      = result.slot_peer;
  assign slot_conn_o      = result.slot_conn;
  assign slots_in_batch_o = result.slots_in_batch;
  assign total_segments_o = result.total_segments;
  assign needs_offload_o  = result.needs_offload;
  assign queue_dry_o      = result.queue_dry;
  assign last_o           = result.last;

endmodule
